@@ rtl/pcc_pkg.sv @@
`default_nettype none
package pcc_pkg;

  typedef enum logic {
    F_IDLE,
    F_ACC
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ROOT,
    B_DECIDE
  } back_state_t;

  // Multiply steps of one pair, in the order the back end runs them
  typedef enum logic [2:0] {
    OP_NXX,
    OP_XX,
    OP_NYY,
    OP_YY,
    OP_NXY,
    OP_XY,
    OP_DEN,
    OP_NUM
  } mul_op_t;

  localparam logic [1:0] MODE_ALL    = 2'd0;
  localparam logic [1:0] MODE_BEST   = 2'd1;
  localparam logic [1:0] MODE_THRESH = 2'd2;

  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
  localparam logic signed [31:0] BEST_RESET = 32'sh8000_0000;
  localparam logic [4:0]         ROOT_TOP   = 5'd30;
  localparam int                 FRAC_SHIFT = 60;

endpackage
`default_nettype wire

@@ rtl/pcc_queue.sv @@
`default_nettype none
module pcc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule
`default_nettype wire

@@ rtl/pcc_front.sv @@
`default_nettype none
module pcc_front #(
  parameter int MAX_ROWS    = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int CW          = 13,
  parameter int SUMW        = 36,
  parameter int SQW         = 59,
  parameter int XYW         = 60,
  parameter int EW          = 320
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] x_value,
  input  wire logic [23:0] y_value,
  input  wire logic        x_ok,
  input  wire logic        y_ok,
  input  wire logic [9:0]  x_col,
  input  wire logic [9:0]  y_col,
  input  wire logic        last_row,
  input  wire logic        last_col,
  output logic             q_push,
  output logic [EW-1:0]    q_din,
  input  wire logic        q_full
);
  import pcc_pkg::*;

  localparam int SB = SAMPLE_BITS;

  front_state_t fstate, fstate_next;

  logic signed [SB-1:0]     rx, ry;
  logic                     rok, rlast, rlc;
  logic [9:0]               rxc, ryc;
  logic [CW-1:0]            cnt, cnt_next;
  logic signed [SUMW-1:0]   sx, sy, sx_next, sy_next;
  logic [SQW-1:0]           sxx, syy, sxx_next, syy_next;
  logic signed [XYW-1:0]    sxy, sxy_next;
  logic signed [2*SB-1:0]   pxx, pyy, pxy;
  logic                     take, commit;

  assign pxx  = rx * rx;
  assign pyy  = ry * ry;
  assign pxy  = rx * ry;
  assign take = rok && (cnt < CW'(MAX_ROWS));

  always_comb begin
    cnt_next = cnt;
    sx_next  = sx;
    sy_next  = sy;
    sxx_next = sxx;
    syy_next = syy;
    sxy_next = sxy;
    if (take) begin
      cnt_next = cnt + 1'b1;
      sx_next  = sx + SUMW'(rx);
      sy_next  = sy + SUMW'(ry);
      sxx_next = sxx + SQW'($unsigned(pxx));
      syy_next = syy + SQW'($unsigned(pyy));
      sxy_next = sxy + XYW'(pxy);
    end
  end

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_IDLE: begin
        if (in_valid) fstate_next = F_ACC;
      end
      F_ACC: begin
        if (!rlast || !q_full) fstate_next = F_IDLE;
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (fstate == F_ACC);
    q_push   = (fstate == F_ACC) && rlast && !q_full;
    commit   = (fstate == F_ACC) && (!rlast || !q_full);
    q_din    = {cnt_next, sx_next, sy_next, sxx_next, syy_next, sxy_next, rxc, ryc, rlc};
  end

  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && in_valid) begin
      rx    <= x_value[SB-1:0];
      ry    <= y_value[SB-1:0];
      rok   <= x_ok & y_ok;
      rlast <= last_row;
      rlc   <= last_col;
      rxc   <= x_col;
      ryc   <= y_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      cnt    <= '0;
      sx     <= '0;
      sy     <= '0;
      sxx    <= '0;
      syy    <= '0;
      sxy    <= '0;
    end else begin
      fstate <= fstate_next;
      if (commit) begin
        // end of pair: start the next pair from zero
        if (rlast) begin
          cnt <= '0;
          sx  <= '0;
          sy  <= '0;
          sxx <= '0;
          syy <= '0;
          sxy <= '0;
        end else begin
          cnt <= cnt_next;
          sx  <= sx_next;
          sy  <= sy_next;
          sxx <= sxx_next;
          syy <= syy_next;
          sxy <= sxy_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/pcc_mul.sv @@
`default_nettype none
module pcc_mul #(
  parameter int W = 73
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [2*W-1:0]    prod
);
  logic           busy;
  logic [2*W-1:0] acc;
  logic [2*W-1:0] sa;
  logic [W-1:0]   sb;

  assign done = busy && (sb == '0);
  assign prod = acc;

  // shift-add, one multiplier bit per cycle, stops once the rest is zero
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      sa  <= (2*W)'(a);
      sb  <= b;
    end else if (busy && sb != '0) begin
      if (sb[0]) acc <= acc + sa;
      sa <= sa << 1;
      sb <= sb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pcc_back.sv @@
`default_nettype none
module pcc_back #(
  parameter int CW   = 13,
  parameter int SUMW = 36,
  parameter int SQW  = 59,
  parameter int XYW  = 60,
  parameter int EW   = 320
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] threshold,
  input  wire logic               q_empty,
  input  wire logic [EW-1:0]      q_dout,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      corr,
  output logic                    corr_na,
  output logic [9:0]              x_col_out,
  output logic [9:0]              y_col_out
);
  import pcc_pkg::*;

  localparam int PW = 2 * SUMW + 1;
  localparam int RW = 2 * PW + FRAC_SHIFT + 2;

  back_state_t bstate, bstate_next;
  mul_op_t     op;

  logic [CW-1:0]          e_n;
  logic signed [SUMW-1:0] e_sx, e_sy;
  logic [SQW-1:0]         e_sxx, e_syy;
  logic signed [XYW-1:0]  e_sxy;
  logic [9:0]             e_xc, e_yc;
  logic                   e_lc;

  logic [CW-1:0]   n_r;
  logic [SUMW-1:0] ax, ay;
  logic [XYW-1:0]  axy;
  logic [SQW-1:0]  sxx_r, syy_r;
  logic            neg_x, neg_y, neg_xy;
  logic [9:0]      xc_r, yc_r;
  logic            lc_r;
  logic [PW-1:0]   t_a, dxx, dyy, m_r;
  logic            neg, ok_r;
  logic [RW-1:0]   rem, u_r, t_r, cand;
  logic [30:0]     lo;
  logic [4:0]      k;

  logic            mul_start, mul_done;
  logic [PW-1:0]   mul_a, mul_b;
  logic [2*PW-1:0] prod;
  logic [PW-1:0]   prod_lo;
  logic            spread_fail;
  logic [PW-1:0]   m_calc;
  logic            neg_calc, sp, sq;

  logic signed [31:0] r_val;
  logic               can_load, load, best_upd;
  logic signed [31:0] nb_corr, best_corr;
  logic [9:0]         nb_col, best_col;
  logic               nb_found, best_found;
  logic               best_write, best_clear;
  logic signed [31:0] o_corr;
  logic               o_na;
  logic [9:0]         o_ycol;

  assign {e_n, e_sx, e_sy, e_sxx, e_syy, e_sxy, e_xc, e_yc, e_lc} = q_dout;

  always_comb begin
    case (op)
      OP_NXX:  begin mul_a = PW'(n_r); mul_b = PW'(sxx_r); end
      OP_XX:   begin mul_a = PW'(ax);  mul_b = PW'(ax);    end
      OP_NYY:  begin mul_a = PW'(n_r); mul_b = PW'(syy_r); end
      OP_YY:   begin mul_a = PW'(ay);  mul_b = PW'(ay);    end
      OP_NXY:  begin mul_a = PW'(n_r); mul_b = PW'(axy);   end
      OP_XY:   begin mul_a = PW'(ax);  mul_b = PW'(ay);    end
      OP_DEN:  begin mul_a = dxx;      mul_b = dyy;        end
      OP_NUM:  begin mul_a = m_r;      mul_b = m_r;        end
      default: begin mul_a = '0;       mul_b = '0;         end
    endcase
  end

  pcc_mul #(.W(PW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign prod_lo     = prod[PW-1:0];
  assign spread_fail = (op == OP_XX || op == OP_YY) && (t_a <= prod_lo);

  // sign-magnitude difference n*Sxy - Sx*Sy
  always_comb begin
    sp = neg_xy;
    sq = neg_x ^ neg_y;
    if (sp != sq) begin
      m_calc   = t_a + prod_lo;
      neg_calc = sp;
    end else if (t_a >= prod_lo) begin
      m_calc   = t_a - prod_lo;
      neg_calc = sp;
    end else begin
      m_calc   = prod_lo - t_a;
      neg_calc = !sp;
    end
  end

  assign cand  = t_r + u_r;
  assign r_val = neg ? -$signed({1'b0, lo}) : $signed({1'b0, lo});

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      B_IDLE: begin
        if (!q_empty) bstate_next = (e_n >= CW'(2)) ? B_MUL : B_DECIDE;
      end
      B_MUL: begin
        if (mul_done) begin
          if (spread_fail) bstate_next = B_DECIDE;
          else if (op == OP_NUM) bstate_next = B_ROOT;
        end
      end
      B_ROOT: begin
        if (k == '0) bstate_next = B_DECIDE;
      end
      B_DECIDE: begin
        if (can_load) bstate_next = B_IDLE;
      end
      default: bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (bstate == B_IDLE) && !q_empty;
    can_load   = !out_valid || !out_stall;
    best_upd   = ok_r && (r_val > best_corr);
    nb_corr    = best_upd ? r_val : best_corr;
    nb_col     = best_upd ? yc_r : best_col;
    nb_found   = best_upd || best_found;
    load       = 1'b0;
    best_write = 1'b0;
    best_clear = 1'b0;
    o_corr     = ok_r ? r_val : '0;
    o_na       = !ok_r;
    o_ycol     = yc_r;
    if (bstate == B_DECIDE && can_load) begin
      case (mode)
        MODE_BEST: begin
          if (lc_r) begin
            load       = 1'b1;
            best_clear = 1'b1;
            o_corr     = nb_found ? nb_corr : '0;
            o_na       = !nb_found;
            o_ycol     = nb_found ? nb_col : '0;
          end else begin
            best_write = 1'b1;
          end
        end
        MODE_THRESH: begin
          load = ok_r && (r_val >= threshold);
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r    <= e_n;
      ax     <= e_sx[SUMW-1] ? SUMW'(-e_sx) : SUMW'(e_sx);
      ay     <= e_sy[SUMW-1] ? SUMW'(-e_sy) : SUMW'(e_sy);
      axy    <= e_sxy[XYW-1] ? XYW'(-e_sxy) : XYW'(e_sxy);
      neg_x  <= e_sx[SUMW-1];
      neg_y  <= e_sy[SUMW-1];
      neg_xy <= e_sxy[XYW-1];
      sxx_r  <= e_sxx;
      syy_r  <= e_syy;
      xc_r   <= e_xc;
      yc_r   <= e_yc;
      lc_r   <= e_lc;
    end
    if (bstate == B_MUL && mul_done) begin
      case (op)
        OP_XX:   dxx <= t_a - prod_lo;
        OP_YY:   dyy <= t_a - prod_lo;
        OP_XY:   begin
          m_r <= m_calc;
          neg <= neg_calc;
        end
        OP_DEN:  begin
          u_r <= RW'(prod) << FRAC_SHIFT;
          t_r <= '0;
        end
        OP_NUM:  begin
          rem <= RW'(prod) << FRAC_SHIFT;
          lo  <= '0;
          k   <= ROOT_TOP;
        end
        default: t_a <= prod_lo;
      endcase
    end
    // one result bit per cycle; t_r tracks 2^(k+1)*lo*L, u_r tracks 2^(2k)*L
    if (bstate == B_ROOT) begin
      if (rem >= cand) begin
        rem <= rem - cand;
        t_r <= (t_r >> 1) + u_r;
        lo  <= lo | (31'(1) << k);
      end else begin
        t_r <= t_r >> 1;
      end
      u_r <= u_r >> 2;
      k   <= k - 1'b1;
    end
    if (load) begin
      corr      <= o_corr;
      corr_na   <= o_na;
      x_col_out <= xc_r;
      y_col_out <= o_ycol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= B_IDLE;
      op         <= OP_NXX;
      mul_start  <= 1'b0;
      ok_r       <= 1'b0;
      out_valid  <= 1'b0;
      best_corr  <= BEST_RESET;
      best_col   <= '0;
      best_found <= 1'b0;
    end else begin
      bstate    <= bstate_next;
      mul_start <= (bstate_next == B_MUL) && (bstate != B_MUL || mul_done);
      if (q_pop) begin
        op   <= OP_NXX;
        ok_r <= (e_n >= CW'(2));
      end else if (bstate == B_MUL && mul_done) begin
        if (spread_fail) ok_r <= 1'b0;
        op <= mul_op_t'(op + 3'd1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (best_clear) begin
        best_corr  <= BEST_RESET;
        best_col   <= '0;
        best_found <= 1'b0;
      end else if (best_write) begin
        best_corr  <= nb_corr;
        best_col   <= nb_col;
        best_found <= nb_found;
      end
    end
  end

  a_root_ok: assert property (@(posedge clk) disable iff (rst) bstate == B_ROOT |-> ok_r)
    else $error("root search on a pair without a correlation");
  a_na_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && corr_na |-> corr == '0)
    else $error("missing correlation with nonzero value");
  a_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (corr <= ONE_Q30) && (corr >= -ONE_Q30))
    else $error("correlation beyond one");

endmodule
`default_nettype wire

@@ rtl/pairwise_complete_correlation.sv @@
`default_nettype none
// Channel   Handshake             Payload
// in        in_valid / in_stall   x_value y_value x_ok y_ok x_col y_col last_row last_col
// out       out_valid / out_stall corr corr_na x_col_out y_col_out
// cfg       cfg_we                cfg_index cfg_data (0 mode, 1 threshold)
//
// In the front end a row is first captured, then squared, multiplied and added.
// On the last row of a pair the sums go to a 2-entry queue; the back end's pace per pair
// is set by its one shift-add multiplier and the bit-by-bit root/divide search.
// Synchronous reset clears all control state and the best-match tracker; no clearing pass.
// A stalled output holds the result; a last row waits while the queue is full.
module pairwise_complete_correlation #(
  parameter int MAX_ROWS    = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] x_value,
  input  wire logic [23:0] y_value,
  input  wire logic        x_ok,
  input  wire logic        y_ok,
  input  wire logic [9:0]  x_col,
  input  wire logic [9:0]  y_col,
  input  wire logic        last_row,
  input  wire logic        last_col,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      corr,
  output logic             corr_na,
  output logic [9:0]       x_col_out,
  output logic [9:0]       y_col_out
);
  import pcc_pkg::*;

  localparam int LG   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam int SUMW = SAMPLE_BITS + LG;
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + LG;
  localparam int XYW  = 2 * SAMPLE_BITS + LG;
  localparam int EW   = CW + 2 * SUMW + 2 * SQW + XYW + 21;

  logic [1:0]         mode;
  logic signed [31:0] threshold;
  logic               q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]      q_din, q_dout;
  logic signed [31:0] corr_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ALL;
      threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[1:0];
        REG_THRESHOLD: threshold <= cfg_data;
        default:       mode      <= mode;
      endcase
    end
  end

  pcc_front #(
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .SUMW        (SUMW),
    .SQW         (SQW),
    .XYW         (XYW),
    .EW          (EW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_value  (x_value),
    .y_value  (y_value),
    .x_ok     (x_ok),
    .y_ok     (y_ok),
    .x_col    (x_col),
    .y_col    (y_col),
    .last_row (last_row),
    .last_col (last_col),
    .q_push   (q_push),
    .q_din    (q_din),
    .q_full   (q_full)
  );

  pcc_queue #(.W(EW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pcc_back #(
    .CW   (CW),
    .SUMW (SUMW),
    .SQW  (SQW),
    .XYW  (XYW),
    .EW   (EW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .threshold (threshold),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .corr      (corr_s),
    .corr_na   (corr_na),
    .x_col_out (x_col_out),
    .y_col_out (y_col_out)
  );

  assign corr = corr_s;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  typedef struct {
    logic [31:0] corr;
    logic        corr_na;
    logic [9:0]  x_col_out;
    logic [9:0]  y_col_out;
  } corr_result_t;

  class pair_corr_scoreboard;
    logic [1:0]           mode;
    logic signed [31:0]   threshold;
    int                   row_count;
    longint               sum_x, sum_y, sum_xy, sum_xx, sum_yy;
    longint               best_corr;
    logic [9:0]           best_col;
    bit                   best_found;
    corr_result_t         expected_q[$];
    int                   errors;

    function new();
      mode = MODE_ALL;
      threshold = 0;
      errors = 0;
      clear_sums();
      clear_best();
    endfunction

    function void clear_sums();
      row_count = 0;
      sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; sum_yy = 0;
    endfunction

    function void clear_best();
      best_corr = -2 * 64'sd1073741824;
      best_col = '0;
      best_found = 0;
    endfunction

    // exact Pearson r of the current sums, truncated toward zero to Q1.30
    function bit pearson_q30(output longint r);
      logic signed [127:0] nn, sx, sy, sxx, syy, sxy, dxx, dyy, num, num_mag;
      logic [255:0]        lhs, rhs, m2, t;
      longint              lo, hi, mid;
      r = 0;
      if (row_count < 2) return 0;
      nn = row_count; sx = sum_x; sy = sum_y;
      sxx = sum_xx; syy = sum_yy; sxy = sum_xy;
      dxx = nn * sxx - sx * sx;
      dyy = nn * syy - sy * sy;
      if (dxx <= 0 || dyy <= 0) return 0;
      num = nn * sxy - sx * sy;
      num_mag = (num < 0) ? -num : num;
      lhs = 256'(dxx) * 256'(dyy);
      rhs = (256'(num_mag) * 256'(num_mag)) << FRAC_SHIFT;
      lo = 0;
      hi = 64'd1073741824;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        m2 = 256'(mid);
        t = m2 * m2 * lhs;
        if (t <= rhs) lo = mid;
        else hi = mid - 1;
      end
      r = (num < 0) ? -lo : lo;
      return 1;
    endfunction

    function void push(longint c, bit na, logic [9:0] xc, logic [9:0] yc);
      corr_result_t e;
      e.corr = c[31:0];
      e.corr_na = na;
      e.x_col_out = xc;
      e.y_col_out = yc;
      expected_q.push_back(e);
    endfunction

    function void note_row(logic [23:0] xv, logic [23:0] yv, logic xok, logic yok,
                           logic [9:0] xc, logic [9:0] yc, logic lr, logic lc);
      longint x, y, r;
      bit     ok;
      x = longint'(signed'(xv));
      y = longint'(signed'(yv));
      if (xok && yok && row_count < 4096) begin
        row_count++;
        sum_x += x; sum_y += y;
        sum_xx += x * x; sum_yy += y * y; sum_xy += x * y;
      end
      if (!lr) return;
      ok = pearson_q30(r);
      clear_sums();
      if (mode == MODE_BEST) begin
        if (ok && r > best_corr) begin
          best_corr = r;
          best_col = yc;
          best_found = 1;
        end
        if (lc) begin
          if (best_found) push(best_corr, 0, xc, best_col);
          else push(0, 1, xc, '0);
          clear_best();
        end
      end else if (mode == MODE_THRESH) begin
        if (ok && r >= longint'(threshold)) push(r, 0, xc, yc);
      end else begin
        push(ok ? r : 0, !ok, xc, yc);
      end
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result corr=%h na=%b x=%0d y=%0d", $time,
                 got.corr, got.corr_na, got.x_col_out, got.y_col_out);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.corr !== e.corr) begin
        $display("%0t: corr expected %h actual %h", $time, e.corr, got.corr);
        errors++;
      end
      if (got.corr_na !== e.corr_na) begin
        $display("%0t: corr_na expected %b actual %b", $time, e.corr_na, got.corr_na);
        errors++;
      end
      if (got.x_col_out !== e.x_col_out) begin
        $display("%0t: x_col_out expected %0d actual %0d", $time, e.x_col_out,
                 got.x_col_out);
        errors++;
      end
      if (got.y_col_out !== e.y_col_out) begin
        $display("%0t: y_col_out expected %0d actual %0d", $time, e.y_col_out,
                 got.y_col_out);
        errors++;
      end
    endfunction
  endclass

  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int     DRAIN_CYCLES = 4000;

  logic        clk, rst;
  logic        cfg_we, cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [23:0] x_value, y_value;
  logic        x_ok, y_ok;
  logic [9:0]  x_col, y_col;
  logic        last_row, last_col;
  logic        out_valid, out_stall;
  logic [31:0] corr;
  logic        corr_na;
  logic [9:0]  x_col_out, y_col_out;

  pair_corr_scoreboard corr_sb;
  longint cycles;
  int     rows_taken;
  int     burst_left;
  int     stall_style;

  pairwise_complete_correlation DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_value(x_value), .y_value(y_value), .x_ok(x_ok), .y_ok(y_ok),
    .x_col(x_col), .y_col(y_col), .last_row(last_row), .last_col(last_col),
    .out_valid(out_valid), .out_stall(out_stall),
    .corr(corr), .corr_na(corr_na), .x_col_out(x_col_out), .y_col_out(y_col_out)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // pre-edge values are seen here since the block updates by nonblocking assignment
  always @(posedge clk) begin
    corr_result_t got;
    cycles++;
    if (!rst && in_valid && !in_stall) begin
      corr_sb.note_row(x_value, y_value, x_ok, y_ok, x_col, y_col, last_row, last_col);
      rows_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      got.corr = corr;
      got.corr_na = corr_na;
      got.x_col_out = x_col_out;
      got.y_col_out = y_col_out;
      corr_sb.check_result(got);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("** pairwise_complete_correlation: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern; style changes now and then, including no stalls at all
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) corr_sb.mode = value[1:0];
    else corr_sb.threshold = value;
  endtask

  // drain pending results, then let the back end finish any pair that emits nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (corr_sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_row(input logic [23:0] xv, input logic [23:0] yv,
                          input logic xok, input logic yok,
                          input logic [9:0] xc, input logic [9:0] yc,
                          input logic lr, input logic lc);
    int taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    x_value <= xv; y_value <= yv; x_ok <= xok; y_ok <= yok;
    x_col <= xc; y_col <= yc; last_row <= lr; last_col <= lc;
    in_valid <= 1'b1;
    taken = rows_taken;
    do @(negedge clk); while (rows_taken == taken);
  endtask

  function automatic logic [23:0] any_sample();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($signed($urandom_range(0, 8191)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  // kind: 0 random, 1 y=x, 2 y=~x, 3 constant x, 4 y near x, 5 mostly missing
  task automatic send_pair(input logic [9:0] xc, input logic [9:0] yc, input int rows,
                           input int kind, input logic lc);
    logic [23:0] xv, yv, cx;
    logic        xok, yok;
    cx = any_sample();
    for (int i = 0; i < rows; i++) begin
      xv = (kind == 3) ? cx : any_sample();
      case (kind)
        1: yv = xv;
        2: yv = ~xv;
        4: yv = xv + 24'($signed($urandom_range(0, 63)) - 32);
        default: yv = any_sample();
      endcase
      xok = (kind == 5) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
      yok = (kind == 5) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
      send_row(xv, yv, xok, yok, xc, yc, i == rows - 1,
               (i == rows - 1) ? lc : logic'($urandom_range(0, 1)));
    end
  endtask

  function automatic int pick_rows();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 7);
  endfunction

  task automatic random_phase(input int items, input bit best);
    int   sent, ncols;
    logic [9:0] xc;
    sent = 0;
    while (sent < items) begin
      xc = 10'($urandom);
      ncols = best ? $urandom_range(1, 5) : 1;
      for (int c = 0; c < ncols; c++) begin
        int rows;
        rows = pick_rows();
        send_pair(xc, 10'($urandom), rows, $urandom_range(0, 5),
                  best ? logic'(c == ncols - 1) : logic'($urandom_range(0, 1)));
        sent += rows;
      end
    end
    settle();
  endtask

  initial begin
    corr_sb = new();
    cycles = 0;
    rows_taken = 0;
    burst_left = 0;
    stall_style = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    x_value = '0; y_value = '0; x_ok = 1'b0; y_ok = 1'b0;
    x_col = '0; y_col = '0; last_row = 1'b0; last_col = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every-pair mode
    write_reg(REG_MODE, MODE_ALL);
    send_row(24'h800000, 24'h7fffff, 1, 1, 10'd0, 10'd1023, 1, 0);   // single row
    send_row(24'h000100, 24'h000200, 0, 1, 10'd1023, 10'd0, 0, 1);   // stray last_col
    send_row(24'h000300, 24'h000200, 1, 0, 10'd1023, 10'd0, 1, 0);   // nothing complete
    send_pair(10'd5, 10'd6, 4, 3, 0);                               // constant x
    send_row(24'h800000, 24'h800000, 1, 1, 10'd7, 10'd8, 0, 0);
    send_row(24'h7fffff, 24'h7fffff, 1, 1, 10'd7, 10'd8, 1, 0);     // r = +1
    send_row(24'h800000, 24'h7fffff, 1, 1, 10'd9, 10'd10, 0, 0);
    send_row(24'h7fffff, 24'h800000, 1, 1, 10'd9, 10'd10, 1, 0);    // r = -1
    send_pair(10'd11, 10'd12, 5, 4, 0);
    settle();
    write_reg(REG_MODE, 2'd3);                                       // unused mode
    send_pair(10'd13, 10'd14, 3, 0, 1);
    send_row(24'h000001, 24'h000001, 1, 1, 10'd13, 10'd15, 1, 1);
    settle();

    // directed: best column, with a tie and a group with nothing found
    write_reg(REG_MODE, MODE_BEST);
    send_row(24'h000010, 24'h000010, 1, 1, 10'd20, 10'd30, 0, 0);
    send_row(24'h000020, 24'h000020, 1, 1, 10'd20, 10'd30, 1, 0);
    send_row(24'h000010, 24'h000011, 1, 1, 10'd20, 10'd31, 0, 0);
    send_row(24'h000020, 24'h000021, 1, 1, 10'd20, 10'd31, 1, 1);
    send_row(24'h000010, 24'h000011, 1, 1, 10'd21, 10'd32, 1, 0);
    send_row(24'h000010, 24'h000011, 0, 1, 10'd21, 10'd33, 1, 1);
    settle();

    // directed: threshold extremes
    write_reg(REG_MODE, MODE_THRESH);
    write_reg(REG_THRESHOLD, 32'hc000_0000);
    send_pair(10'd40, 10'd41, 4, 2, 0);
    send_pair(10'd42, 10'd43, 3, 0, 0);
    settle();
    write_reg(REG_THRESHOLD, 32'h4000_0000);
    send_pair(10'd44, 10'd45, 3, 1, 0);
    send_pair(10'd46, 10'd47, 3, 4, 0);
    settle();

    // random phases over several settings
    write_reg(REG_MODE, MODE_ALL);
    random_phase(250, 0);
    write_reg(REG_MODE, MODE_BEST);
    random_phase(300, 1);
    write_reg(REG_MODE, MODE_THRESH);
    write_reg(REG_THRESHOLD, 32'h0);
    random_phase(200, 0);
    write_reg(REG_THRESHOLD, 32'($signed($urandom_range(0, 32'h7fff_ffff)) % 32'sh4000_0001));
    random_phase(150, 0);
    write_reg(REG_MODE, 2'd3);
    random_phase(150, 0);

    if (corr_sb.errors == 0 && corr_sb.expected_q.size() == 0)
      $display("** pairwise_complete_correlation: PASSED **");
    else
      $display("** pairwise_complete_correlation: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
